### hdl/kmpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmpt_pkg;

	// table geometry
	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);

	// payload widths
	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 32;
	localparam int PRICE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 32;
	localparam int ROW_W    = KEY_W + PRICE_W;

	// item operations
	typedef enum logic [FUNC_W-1:0] {
		FN_SET    = 2'd0,
		FN_UPDATE = 2'd1,
		FN_POP    = 2'd2
	} func_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic             load;     // capture a new transaction
		logic             rd_en;    // read one table row
		logic [IDX_W-1:0] rd_addr;  // row being read
		logic             commit;   // apply the result and load the output register
	} cmd_t;

endpackage

`default_nettype wire

### hdl/kmpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kmpt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/kmpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kmpt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output kmpt_pkg::cmd_t      cmd
);
	import kmpt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_TAIL   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t           state_q;
	logic [IDX_W-1:0] addr_q;
	logic             out_valid_q;
	logic             accept;
	logic             commit;

	assign accept = (state_q == S_IDLE) && in_valid;
	// output register must be free, or emptied in this cycle
	assign commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load    = accept;
	assign cmd.rd_en   = (state_q == S_SCAN);
	assign cmd.rd_addr = addr_q;
	assign cmd.commit  = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q == LAST_IDX) begin
						state_q <= S_TAIL;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_TAIL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(commit))
		else $error("result appeared without a commit");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN) && (addr_q == '0))
		else $error("accepted transaction did not start a scan at row zero");

	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) == S_SCAN) |-> addr_q == $past(addr_q) + 1'b1)
		else $error("scan address skipped a row");

	a_tail_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL) |=> (state_q == S_COMMIT))
		else $error("tail cycle not followed by commit");
`endif

endmodule

`default_nettype wire

### hdl/kmpt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module kmpt_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire kmpt_pkg::cmd_t                 cmd,
	input  wire logic [kmpt_pkg::FUNC_W-1:0]    func,
	input  wire logic [kmpt_pkg::KEY_W-1:0]     stock_key,
	input  wire logic [kmpt_pkg::PRICE_W-1:0]   price,
	output logic      [kmpt_pkg::STATUS_W-1:0]  status,
	output logic      [kmpt_pkg::KEY_W-1:0]     popped_key,
	output logic      [kmpt_pkg::COUNT_W-1:0]   item_number
);
	import kmpt_pkg::*;

	// captured transaction
	func_t                func_q;
	logic [KEY_W-1:0]     key_q;
	logic [PRICE_W-1:0]   price_q;
	logic [COUNT_W-1:0]   item_cnt_q;

	// table occupancy and displacement mask
	logic [ENTRIES-1:0]   valid_q;
	logic [ENTRIES-1:0]   mask_q;

	// scan results
	logic                 match_found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 min_found_q;
	logic [IDX_W-1:0]     min_idx_q;
	logic [PRICE_W-1:0]   min_price_q;
	logic [KEY_W-1:0]     min_key_q;

	// compare stage
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;

	// output register
	status_t              status_q;
	logic [KEY_W-1:0]     popped_q;
	logic [COUNT_W-1:0]   itemno_q;

	logic [ROW_W-1:0]     rd_data;
	logic [KEY_W-1:0]     row_key;
	logic [PRICE_W-1:0]   row_price;
	logic                 row_valid;
	logic                 hit_key;
	logic                 same_price;
	logic                 row_free;
	logic                 row_less;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	status_t              sts;
	logic [KEY_W-1:0]     pop_key;
	logic [ENTRIES-1:0]   valid_nx;

	kmpt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ENTRIES)
	) u_rows (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx),
		.wr_data ({key_q, price_q}),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.rd_addr),
		.rd_data (rd_data)
	);

	assign row_key   = rd_data[ROW_W-1:PRICE_W];
	assign row_price = rd_data[PRICE_W-1:0];
	assign row_valid = valid_q[idx_s1];

	assign hit_key    = row_valid && (row_key == key_q);
	// another key at the new price gets displaced
	assign same_price = row_valid && (row_price == price_q) && (row_key != key_q);
	assign row_free   = !row_valid || same_price;
	assign row_less   = row_valid && (!min_found_q || (row_price < min_price_q));

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = match_idx_q;
		sts      = STS_OK;
		pop_key  = '0;
		valid_nx = valid_q;
		unique case (func_q)
			FN_SET: begin
				if (match_found_q) begin
					wr_en  = 1'b1;
					wr_idx = match_idx_q;
				end else if (free_found_q) begin
					wr_en  = 1'b1;
					wr_idx = free_idx_q;
				end else begin
					sts = STS_FULL;
				end
				if (wr_en) begin
					valid_nx = (valid_q & ~mask_q) | (ENTRIES'(1) << wr_idx);
				end
			end
			FN_UPDATE: begin
				if (match_found_q) begin
					wr_en    = 1'b1;
					valid_nx = valid_q & ~mask_q;
				end else begin
					sts = STS_NOT_FOUND;
				end
			end
			FN_POP: begin
				if (min_found_q) begin
					valid_nx[min_idx_q] = 1'b0;
					pop_key             = min_key_q;
				end else begin
					sts = STS_EMPTY;
				end
			end
			default: begin
			end
		endcase
		wr_en = wr_en && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q    <= '0;
			valid_q       <= '0;
			mask_q        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			min_found_q   <= 1'b0;
			vld_s1        <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				item_cnt_q    <= item_cnt_q + 1'b1;
				mask_q        <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				min_found_q   <= 1'b0;
			end else if (vld_s1) begin
				mask_q[idx_s1] <= same_price;
				if (hit_key && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (row_free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (row_less) begin
					min_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				valid_q <= valid_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func_t'(func);
			key_q   <= stock_key;
			price_q <= price;
		end
		if (cmd.rd_en) begin
			idx_s1 <= cmd.rd_addr;
		end
		if (vld_s1 && !cmd.load) begin
			if (hit_key && !match_found_q) begin
				match_idx_q <= idx_s1;
			end
			if (row_free && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (row_less) begin
				min_idx_q   <= idx_s1;
				min_price_q <= row_price;
				min_key_q   <= row_key;
			end
		end
		if (cmd.commit) begin
			status_q <= sts;
			popped_q <= pop_key;
			itemno_q <= item_cnt_q;
		end
	end

	assign status      = status_q;
	assign popped_key  = popped_q;
	assign item_number = itemno_q;

endmodule

`default_nettype wire

### hdl/keyed_min_price_table.sv
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  in       | in_valid, in_stall  | func, stock_key, price
//  out      | out_valid, out_stall| status, popped_key, item_number
//
//  every transaction captures its inputs, reads each table row in turn through
//  the single read port of the row memory, finishes the last compare and then
//  commits into the output register.
//  reset clears the valid bits and the item counter; row contents stay undefined
//  and are only read behind a valid bit, so no clearing pass is needed.
//  a finished result waits in the output register while the next transaction
//  is taken; commit holds only if that register is still full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module keyed_min_price_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input transaction
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [kmpt_pkg::FUNC_W-1:0]    func,
	input  wire logic [kmpt_pkg::KEY_W-1:0]     stock_key,
	input  wire logic [kmpt_pkg::PRICE_W-1:0]   price,
	// result transaction
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [kmpt_pkg::STATUS_W-1:0]  status,
	output logic      [kmpt_pkg::KEY_W-1:0]     popped_key,
	output logic      [kmpt_pkg::COUNT_W-1:0]   item_number
);
	import kmpt_pkg::*;

	// sequencing commands from the controller: capture, row reads, commit
	cmd_t cmd;

	// controller: idle, scan over all rows, tail compare, commit
	kmpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath: row memory, valid bits, key/price compares, min tracking,
	// displacement mask and the output register
	kmpt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.stock_key   (stock_key),
		.price       (price),
		.status      (status),
		.popped_key  (popped_key),
		.item_number (item_number)
	);

endmodule

`default_nettype wire
